>>> rtl/multi_key_debounce_click_long_press_defines.svh
// Assertion macros for the key debouncer. The clock is clk and the reset is arst_n
// in every module that uses them.
`ifndef MULTI_KEY_DEBOUNCE_CLICK_LONG_PRESS_DEFINES_SVH
`define MULTI_KEY_DEBOUNCE_CLICK_LONG_PRESS_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define MKDB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define MKDB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MKDB_ASSERT_NOW(lbl, ante, cons, msg)
`define MKDB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/mkdb_pkg.sv
`timescale 1ns / 1ps

package mkdb_pkg;

	localparam int KEY_BITS     = 8;
	localparam int NUM_KEYS_DEF = 8;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [15:0]         DEBOUNCE_RST  = 16'd20;
	localparam logic [15:0]         LONG_RST      = 16'd1000;
	localparam logic                ACT_LOW_RST   = 1'b1;
	localparam logic [KEY_BITS-1:0] KEY_EN_RST    = 8'hFF;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_ACT_LOW  = 2'd2,
		REG_KEY_EN   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_POLL    = 1'b0,
		OP_CAPTURE = 1'b1
	} opcode_t;

	typedef struct packed {
		logic                opcode;
		logic [31:0]         time_ms;
		logic [KEY_BITS-1:0] pin_levels;
		logic [KEY_BITS-1:0] read_ok;
	} in_word_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] press_down_events;
		logic [KEY_BITS-1:0] press_up_events;
		logic [KEY_BITS-1:0] click_events;
		logic [KEY_BITS-1:0] long_press_events;
	} out_word_t;

	// Settings as the key lanes see them; debounce is already forced to at least one.
	typedef struct packed {
		logic [15:0]         debounce;
		logic [15:0]         long_time;
		logic                pin_inv;
		logic [KEY_BITS-1:0] key_en;
	} cfg_t;

	typedef struct packed {
		logic down;
		logic up;
		logic click;
		logic lng;
	} lane_evt_t;

endpackage

>>> rtl/mkdb_ifs.sv
`timescale 1ns / 1ps

interface mkdb_smp_if;
	logic                valid;
	logic                ready;
	mkdb_pkg::in_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mkdb_evt_if;
	logic                valid;
	logic                ready;
	mkdb_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/mkdb_cfg.sv
`timescale 1ns / 1ps

module mkdb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mkdb_pkg::ADDR_W-1:0]   paddr,
	input  logic [mkdb_pkg::DATA_W-1:0]   pwdata,
	output logic [mkdb_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output mkdb_pkg::cfg_t                cfg
);

	logic [15:0]                   debounce_q;
	logic [15:0]                   long_q;
	logic                          act_low_q;
	logic [mkdb_pkg::KEY_BITS-1:0] key_en_q;
	logic                          wr_en;
	mkdb_pkg::reg_idx_t            idx;

	assign pready = 1'b1;
	assign idx    = mkdb_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= mkdb_pkg::DEBOUNCE_RST;
			long_q     <= mkdb_pkg::LONG_RST;
			act_low_q  <= mkdb_pkg::ACT_LOW_RST;
			key_en_q   <= mkdb_pkg::KEY_EN_RST;
		end else if (wr_en) begin
			case (idx)
				mkdb_pkg::REG_DEBOUNCE: debounce_q <= pwdata[15:0];
				mkdb_pkg::REG_LONG:     long_q     <= pwdata[15:0];
				mkdb_pkg::REG_ACT_LOW:  act_low_q  <= pwdata[0];
				mkdb_pkg::REG_KEY_EN:   key_en_q   <= pwdata[mkdb_pkg::KEY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			mkdb_pkg::REG_DEBOUNCE: prdata[15:0] = debounce_q;
			mkdb_pkg::REG_LONG:     prdata[15:0] = long_q;
			mkdb_pkg::REG_ACT_LOW:  prdata[0]    = act_low_q;
			mkdb_pkg::REG_KEY_EN:   prdata[mkdb_pkg::KEY_BITS-1:0] = key_en_q;
			default: prdata = '0;
		endcase
	end

	// a zero debounce acts as one millisecond
	assign cfg.debounce  = (debounce_q == 16'd0) ? 16'd1 : debounce_q;
	assign cfg.long_time = long_q;
	assign cfg.pin_inv   = act_low_q;
	assign cfg.key_en    = key_en_q;

endmodule

>>> rtl/mkdb_lane.sv
`timescale 1ns / 1ps

module mkdb_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  key_en,
	input  logic                  opcode,
	input  logic [31:0]           now,
	input  logic                  level,
	input  logic                  ok,
	input  logic [15:0]           debounce,
	input  logic [15:0]           long_time,
	input  logic                  pin_inv,
	output mkdb_pkg::lane_evt_t   evt
);

	logic        raw_q, stable_q, long_fired_q;
	logic [31:0] raw_time_q, press_time_q;

	logic        raw_d, stable_d, long_fired_d;
	logic [31:0] raw_time_d, press_time_d;
	logic        pressed, raw_chg, settle, held_long, cap_p;
	logic [31:0] since_raw, since_press;

	assign pressed     = level ^ pin_inv;
	assign cap_p       = pressed & ok;
	assign since_raw   = now - raw_time_q;
	assign since_press = now - press_time_q;
	assign raw_chg     = pressed != raw_q;
	// a fresh raw change restarts the timer, so it cannot settle in the same word
	assign settle      = !raw_chg && (raw_q != stable_q) &&
	                     (since_raw >= {16'd0, debounce});
	assign held_long   = stable_q && !settle && !long_fired_q && (long_time != 16'd0) &&
	                     (since_press >= {16'd0, long_time});

	always_comb begin
		raw_d        = raw_q;
		stable_d     = stable_q;
		long_fired_d = long_fired_q;
		raw_time_d   = raw_time_q;
		press_time_d = press_time_q;
		evt          = '0;
		if (advance && key_en) begin
			if (opcode == mkdb_pkg::OP_CAPTURE) begin
				raw_d        = cap_p;
				stable_d     = cap_p;
				raw_time_d   = now;
				press_time_d = cap_p ? now : 32'd0;
				long_fired_d = 1'b0;
			end else if (ok) begin
				raw_d = pressed;
				if (raw_chg) begin
					raw_time_d = now;
				end
				if (settle) begin
					stable_d = raw_q;
					if (raw_q) begin
						press_time_d = now;
						long_fired_d = 1'b0;
						evt.down     = 1'b1;
					end else begin
						evt.up    = 1'b1;
						evt.click = !long_fired_q;
					end
				end
				if (held_long) begin
					long_fired_d = 1'b1;
					evt.lng      = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q        <= 1'b0;
			stable_q     <= 1'b0;
			long_fired_q <= 1'b0;
			raw_time_q   <= '0;
			press_time_q <= '0;
		end else begin
			raw_q        <= raw_d;
			stable_q     <= stable_d;
			long_fired_q <= long_fired_d;
			raw_time_q   <= raw_time_d;
			press_time_q <= press_time_d;
		end
	end

endmodule

>>> rtl/multi_key_debounce_click_long_press.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake       Word
// smp      in   valid / ready   opcode, time_ms, pin_levels, read_ok
// evt      out  valid / ready   press_down, press_up, click, long_press event masks
// apb      cfg  psel / penable  debounce_time, long_press_time, polarity, key_enable_mask
//
// One word per cycle while results are taken; an accepted word passes through the input
// stage and then the result register. All key lanes work on the staged word in parallel
// (two 32-bit subtract-compares per key) and update their state as the result
// register loads. Reset clears all key state, the stage and result valid flags, and
// loads the register defaults. A stalled result holds the input stage, which still
// takes a new word whenever the result is taken in the same cycle.

`include "multi_key_debounce_click_long_press_defines.svh"

module multi_key_debounce_click_long_press #(
	parameter int NUM_KEYS = mkdb_pkg::NUM_KEYS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mkdb_smp_if.sink                    smp,
	mkdb_evt_if.source                  evt,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mkdb_pkg::ADDR_W-1:0] paddr,
	input  logic [mkdb_pkg::DATA_W-1:0] pwdata,
	output logic [mkdb_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	// keys past the sample width have no pins, so no lane is built for them
	localparam int NUM_LANES = (NUM_KEYS < mkdb_pkg::KEY_BITS) ? NUM_KEYS : mkdb_pkg::KEY_BITS;

	mkdb_pkg::cfg_t      cfg;
	mkdb_pkg::in_word_t  word_s1;
	logic                valid_s1;
	mkdb_pkg::out_word_t res_q;
	logic                res_valid_q;
	logic                advance;
	mkdb_pkg::out_word_t res_d;
	mkdb_pkg::lane_evt_t lane_evt [NUM_LANES];

	mkdb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the stage whenever the result register is free or being drained
	assign advance   = valid_s1 && (!res_valid_q || evt.ready);
	assign smp.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp.valid && smp.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (smp.valid && smp.ready) begin
			word_s1 <= smp.data;
		end
	end

	genvar k;
	generate
		for (k = 0; k < NUM_LANES; k++) begin : g_lane
			mkdb_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.advance    (advance),
				.key_en     (cfg.key_en[k]),
				.opcode     (word_s1.opcode),
				.now        (word_s1.time_ms),
				.level      (word_s1.pin_levels[k]),
				.ok         (word_s1.read_ok[k]),
				.debounce   (cfg.debounce),
				.long_time  (cfg.long_time),
				.pin_inv    (cfg.pin_inv),
				.evt        (lane_evt[k])
			);
		end
		// gather lane events into the result word; missing keys report nothing
		for (k = 0; k < mkdb_pkg::KEY_BITS; k++) begin : g_bit
			if (k < NUM_LANES) begin : g_on
				assign res_d.press_down_events[k] = lane_evt[k].down;
				assign res_d.press_up_events[k]   = lane_evt[k].up;
				assign res_d.click_events[k]      = lane_evt[k].click;
				assign res_d.long_press_events[k] = lane_evt[k].lng;
			end else begin : g_off
				assign res_d.press_down_events[k] = 1'b0;
				assign res_d.press_up_events[k]   = 1'b0;
				assign res_d.click_events[k]      = 1'b0;
				assign res_d.long_press_events[k] = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (evt.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign evt.valid = res_valid_q;
	assign evt.data  = res_q;

	`MKDB_ASSERT_NEXT(a_adv_loads_res, advance, res_valid_q, "stage advanced but no result")
	`MKDB_ASSERT_NEXT(a_stage_kept, valid_s1 && !advance, valid_s1, "stalled word dropped")
	`MKDB_ASSERT_NEXT(a_capture_silent, advance && (word_s1.opcode == mkdb_pkg::OP_CAPTURE), res_q == '0, "capture reported events")
	`MKDB_ASSERT_NOW(a_click_on_up, res_valid_q, (res_q.click_events & ~res_q.press_up_events) == '0, "click without release")
	`MKDB_ASSERT_NOW(a_down_up_apart, res_valid_q, (res_q.press_down_events & res_q.press_up_events) == '0, "press and release together")

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import mkdb_pkg::*;

	// Clock, reset and the configuration port
	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	mkdb_smp_if smp_bus ();
	mkdb_evt_if evt_bus ();

	multi_key_debounce_click_long_press dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp     (smp_bus),
		.evt     (evt_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 12 ns period: six high, six low
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Words waiting to be sent and event masks waiting to come back
	in_word_t  pending_words[$];
	out_word_t expected_events[$];

	int mismatch_count = 0;
	int idle_max       = 0;
	int gap_left       = 0;
	int stall_left     = 0;
	logic smp_taken    = 1'b0;
	logic evt_taken    = 1'b0;

	// Our own copy of the register file, kept in step with every write
	logic [15:0]         cfg_debounce;
	logic [15:0]         cfg_long;
	logic                cfg_pin_inv;
	logic [KEY_BITS-1:0] cfg_key_en;

	// Our own copy of the per-key state
	logic [KEY_BITS-1:0] key_raw;
	logic [KEY_BITS-1:0] key_stable;
	logic [KEY_BITS-1:0] key_fired;
	logic [31:0]         raw_since  [KEY_BITS];
	logic [31:0]         held_since [KEY_BITS];

	// Stimulus state: running clock in ms and the keys the "user" is holding
	logic [31:0]         now_ms;
	logic [KEY_BITS-1:0] held_keys;

	task automatic report_mismatch(input string what);
		if (mismatch_count < 200)
			$display("MISMATCH at %0t ns: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [KEY_BITS-1:0] got,
			input logic [KEY_BITS-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %02h, expected %02h", name, got, want));
	endtask

	// Work out the event masks one sample word causes, and advance the key state.
	// Disabled keys are left alone whatever the opcode; a failed read skips the key
	// in a poll and forces it to released in a capture.
	function automatic out_word_t predict_events(input in_word_t w);
		out_word_t   ev;
		logic [31:0] settle;
		logic        pressed;
		int          k;
		ev = '0;
		// a debounce time of zero behaves as one millisecond
		settle = (cfg_debounce == 16'd0) ? 32'd1 : {16'd0, cfg_debounce};
		for (k = 0; k < KEY_BITS; k++) begin
			if (cfg_key_en[k]) begin
				pressed = w.pin_levels[k] ^ cfg_pin_inv;
				if (w.opcode == OP_CAPTURE) begin
					pressed       = pressed & w.read_ok[k];
					key_raw[k]    = pressed;
					key_stable[k] = pressed;
					raw_since[k]  = w.time_ms;
					held_since[k] = pressed ? w.time_ms : 32'd0;
					key_fired[k]  = 1'b0;
				end else if (w.read_ok[k]) begin
					if (pressed != key_raw[k]) begin
						key_raw[k]   = pressed;
						raw_since[k] = w.time_ms;
					end
					// all time differences wrap at 32 bits
					if (key_raw[k] != key_stable[k] && (w.time_ms - raw_since[k]) >= settle) begin
						key_stable[k] = key_raw[k];
						if (key_stable[k]) begin
							held_since[k]           = w.time_ms;
							key_fired[k]            = 1'b0;
							ev.press_down_events[k] = 1'b1;
						end else begin
							ev.press_up_events[k] = 1'b1;
							// no click once the long press has gone off
							if (!key_fired[k])
								ev.click_events[k] = 1'b1;
						end
					end
					if (key_stable[k] && !key_fired[k] && cfg_long != 16'd0 &&
							(w.time_ms - held_since[k]) >= {16'd0, cfg_long}) begin
						key_fired[k]            = 1'b1;
						ev.long_press_events[k] = 1'b1;
					end
				end
			end
		end
		return ev;
	endfunction

	// Two-phase register write: setup, then access; the write lands at the
	// rising edge with psel, penable, pwrite and pready all high.
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEBOUNCE: cfg_debounce = value[15:0];
			REG_LONG:     cfg_long     = value[15:0];
			REG_ACT_LOW:  cfg_pin_inv  = value[0];
			REG_KEY_EN:   cfg_key_en   = value[KEY_BITS-1:0];
			default:      ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic queue_sample(input opcode_t op, input logic [31:0] t,
			input logic [KEY_BITS-1:0] pins, input logic [KEY_BITS-1:0] ok);
		in_word_t w;
		w.opcode     = op;
		w.time_ms    = t;
		w.pin_levels = pins;
		w.read_ok    = ok;
		pending_words.push_back(w);
	endtask

	// Wait until every word is sent and every expected result is back, then
	// let the pipeline (input stage and result register) settle a little longer.
	task automatic drain();
		while (pending_words.size() != 0 || smp_bus.valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One random phase: set the registers while idle, then send keys that are held
	// for a while and toggled now and then, with bounce, failed reads, the odd
	// capture and the odd jump anywhere on the 32-bit clock.
	task automatic run_phase(input logic [15:0] deb, input logic [15:0] lng,
			input logic act, input logic [KEY_BITS-1:0] mask, input int step_max,
			input int idle, input int count, input logic [31:0] start);
		logic [KEY_BITS-1:0] bounce;
		logic [KEY_BITS-1:0] ok;
		opcode_t             op;
		int                  n;
		int                  k;
		write_reg(REG_DEBOUNCE, {16'd0, deb});
		write_reg(REG_LONG, {16'd0, lng});
		write_reg(REG_ACT_LOW, {31'd0, act});
		write_reg(REG_KEY_EN, {{(DATA_W-KEY_BITS){1'b0}}, mask});
		idle_max = idle;
		now_ms   = start;
		for (n = 0; n < count; n++) begin
			for (k = 0; k < KEY_BITS; k++)
				if ($urandom_range(0, 15) == 0)
					held_keys[k] = ~held_keys[k];
			if ($urandom_range(0, 39) == 0)
				now_ms = $urandom();
			else
				now_ms = now_ms + $urandom_range(0, step_max);
			bounce = ($urandom_range(0, 4) == 0) ? KEY_BITS'($urandom() & $urandom()) : '0;
			ok     = ($urandom_range(0, 4) == 0) ? KEY_BITS'($urandom()) : '1;
			op     = ($urandom_range(0, 39) == 0) ? OP_CAPTURE : OP_POLL;
			queue_sample(op, now_ms, held_keys ^ {KEY_BITS{act}} ^ bounce, ok);
		end
		drain();
	endtask

	// Driver: present the next word at the falling edge, hold it until taken,
	// then idle for the gap drawn for it.
	always @(negedge clk) begin
		if (arst_n) begin
			if (smp_bus.valid && !smp_taken) begin
				// hold: the word has not been taken yet
			end else if (gap_left > 0) begin
				smp_bus.valid <= 1'b0;
				gap_left--;
			end else if (pending_words.size() != 0) begin
				smp_bus.data  <= pending_words.pop_front();
				smp_bus.valid <= 1'b1;
				gap_left = $urandom_range(0, idle_max);
			end else begin
				smp_bus.valid <= 1'b0;
			end
		end
	end

	// Receiver: after every result taken, draw a fresh stall and drop ready for it
	always @(negedge clk) begin
		if (arst_n) begin
			if (evt_taken)
				stall_left = $urandom_range(0, idle_max);
			if (stall_left > 0) begin
				evt_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				evt_bus.ready <= 1'b1;
			end
		end
	end

	// Monitor: sample both handshakes at the rising edge, predict from every
	// accepted sample word and check every accepted result against the oldest
	// expectation.
	always @(posedge clk) begin : monitor
		out_word_t want;
		out_word_t got;
		smp_taken <= arst_n && smp_bus.valid && smp_bus.ready;
		evt_taken <= arst_n && evt_bus.valid && evt_bus.ready;
		if (arst_n) begin
			if (smp_bus.valid && smp_bus.ready)
				expected_events.push_back(predict_events(smp_bus.data));
			if (evt_bus.valid && evt_bus.ready) begin
				got = evt_bus.data;
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("result %08h with nothing expected", got));
				end else begin
					want = expected_events.pop_front();
					check_field("press_down", got.press_down_events, want.press_down_events);
					check_field("press_up", got.press_up_events, want.press_up_events);
					check_field("click", got.click_events, want.click_events);
					check_field("long_press", got.long_press_events, want.long_press_events);
				end
			end
		end
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int k;
		// Initialise every input of the block and the model before the first edge
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		smp_bus.valid = 1'b0;
		smp_bus.data  = '0;
		evt_bus.ready = 1'b0;
		cfg_debounce  = DEBOUNCE_RST;
		cfg_long      = LONG_RST;
		cfg_pin_inv   = ACT_LOW_RST;
		cfg_key_en    = KEY_EN_RST;
		key_raw    = '0;
		key_stable = '0;
		key_fired  = '0;
		for (k = 0; k < KEY_BITS; k++) begin
			raw_since[k]  = '0;
			held_since[k] = '0;
		end
		held_keys = '0;
		now_ms    = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset settings (20 ms debounce, 1 s long press, active low).
		// Poll straight out of reset without a capture.
		queue_sample(OP_POLL, 32'd0, 8'hFF, 8'hFF);
		queue_sample(OP_POLL, 32'd5, 8'h00, 8'hFF);
		queue_sample(OP_POLL, 32'd25, 8'h00, 8'hFF);
		// Capture with failed reads on the low nibble: those keys come up released
		queue_sample(OP_CAPTURE, 32'd30, 8'h0F, 8'hF0);
		// Long press on the upper nibble, then release with some reads failing
		queue_sample(OP_POLL, 32'd1030, 8'h0F, 8'hFF);
		queue_sample(OP_POLL, 32'd1031, 8'hFF, 8'h3F);
		queue_sample(OP_POLL, 32'd1051, 8'hFF, 8'hFF);
		queue_sample(OP_POLL, 32'd1071, 8'hFF, 8'hFF);
		// Glitch shorter than the debounce, then a clean click on key 0
		queue_sample(OP_POLL, 32'd1080, 8'hFE, 8'hFF);
		queue_sample(OP_POLL, 32'd1090, 8'hFF, 8'hFF);
		queue_sample(OP_POLL, 32'd1100, 8'hFE, 8'hFF);
		queue_sample(OP_POLL, 32'd1120, 8'hFE, 8'hFF);
		queue_sample(OP_POLL, 32'd1130, 8'hFF, 8'hFF);
		queue_sample(OP_POLL, 32'd1150, 8'hFF, 8'hFF);
		// Debounce across the 32-bit wrap of the ms counter
		queue_sample(OP_POLL, 32'hFFFF_FFF0, 8'h00, 8'hFF);
		queue_sample(OP_POLL, 32'h0000_0004, 8'h00, 8'hFF);
		queue_sample(OP_POLL, 32'hFFFF_FFFF, 8'h00, 8'h00);
		idle_max = 3;
		drain();

		// Directed, zero debounce, long press off, active high, half the keys off
		write_reg(REG_DEBOUNCE, 32'd0);
		write_reg(REG_LONG, 32'd0);
		write_reg(REG_ACT_LOW, 32'd0);
		write_reg(REG_KEY_EN, 32'h5A);
		queue_sample(OP_CAPTURE, 32'd100, 8'h00, 8'hFF);
		queue_sample(OP_POLL, 32'd100, 8'hFF, 8'hFF);
		queue_sample(OP_POLL, 32'd101, 8'hFF, 8'hFF);
		queue_sample(OP_POLL, 32'd70000, 8'hFF, 8'hFF);
		queue_sample(OP_POLL, 32'd70001, 8'h00, 8'hFF);
		queue_sample(OP_POLL, 32'd70002, 8'h00, 8'hFF);
		// Capture with every read failed, then a poll with every read failed
		queue_sample(OP_CAPTURE, 32'd5, 8'hFF, 8'h00);
		queue_sample(OP_POLL, 32'd6, 8'hFF, 8'h00);
		drain();

		// Random phases; each one starts from an idle block, so the sender has
		// stopped until every expected result is back before the writes.
		run_phase(16'd1, 16'd0, 1'b0, 8'hFF, 3, 9, 200, now_ms);
		run_phase(16'd0, 16'd6, 1'b1, 8'hFF, 2, 0, 200, now_ms);
		run_phase(16'hFFFF, 16'hFFFF, 1'b0, 8'hFF, 65535, 9, 200, 32'hFFF0_0000);
		run_phase(16'd20, 16'd150, 1'b1, 8'hA5, 20, 5, 200, now_ms);
		run_phase(16'd5, 16'd30, 1'b0, 8'h00, 8, 9, 60, now_ms);
		run_phase(16'($urandom_range(1, 40)), 16'($urandom_range(0, 300)),
			1'($urandom_range(0, 1)), 8'($urandom()), 25, 9, 250, now_ms);
		run_phase(16'd12, 16'd60, 1'b1, 8'hFF, 10, 3, 300, 32'hFFFF_FF00);

		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_events.size()));
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
